// ===== hw/rtl/lmp_pkg.sv =====
package lmp_pkg;

  // shadow memory geometry (power of two, 16 to 128)
  localparam int CELLS   = 128;
  localparam int CELL_AW = $clog2(CELLS);

  // frame layout
  localparam int         FRAME_W = 14;
  localparam logic [2:0] ID_CMD  = 3'b100;
  localparam logic [2:0] ID_WR   = 3'b101;
  localparam logic [3:0] LEN_CMD = 4'd12;
  localparam logic [3:0] LEN_WR  = 4'd14;

  // item codes
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_PLOT  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // register indexes and reset values
  localparam logic       REG_MAX_COLUMN = 1'b0;
  localparam logic       REG_MAX_ROW    = 1'b1;
  localparam logic [5:0] MAX_COLUMN_RST = 6'd31;
  localparam logic [2:0] MAX_ROW_RST    = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_READ,
    ST_UPDATE,
    ST_SEND
  } state_t;

endpackage

// ===== hw/rtl/lmp_ram.sv =====
module lmp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/led_matrix_plot_and_frame_sender_core.sv =====
// Serial front end for a three-wire LED matrix driver. Raise start with an
// item while busy is low; the item is taken at that edge. Each serial bit is
// shown for exactly one cycle with strobe high, MSB first, and frame_end
// marks the last bit of a frame; the receiver cannot hold bits off, so it
// must take one bit every cycle. A command frame gives 12 strobes, a nibble
// write 14. A plot runs the coordinates through a shared one-bit-per-cycle
// remainder unit, first for x and then for y, reads and updates the shadow
// word, then sends 14 bits unless ram_only is set. A dropped plot and the
// unused code leave busy low. The shadow memory reads as zero after reset
// through per-word valid bits, so no clearing pass is needed. Configuration
// is written with cfg_we; the user must do so only while the block is idle,
// as the block itself does not enforce it.
module led_matrix_plot_and_frame_sender_core
  import lmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [7:0] command_byte,
  input  logic [6:0] word_address,
  input  logic [3:0] nibble,
  input  logic [7:0] pixel_x,
  input  logic [7:0] pixel_y,
  input  logic       pixel_on,
  input  logic       wrap_mode,
  input  logic       ram_only,
  output logic       strobe,
  output logic       serial_bit,
  output logic       frame_end
);

  state_t state, state_next;

  logic [5:0] col_limit;
  logic [2:0] max_row;

  // latched plot item
  logic [7:0] px, py;
  logic       p_on, p_wrap, p_ram_only;

  // shared remainder unit
  logic [7:0] div_num;
  logic [5:0] div_den;
  logic [5:0] rem;
  logic [2:0] div_cnt;
  logic [6:0] trial;
  logic [5:0] rem_step;

  logic [5:0] fx;
  logic [2:0] fy_step;
  logic [6:0] wr_addr;
  logic [1:0] plot_sel;

  logic [FRAME_W-1:0] frame;
  logic [3:0]         bits_left;

  logic [CELLS-1:0]   cell_valid;
  logic [CELL_AW-1:0] cell_idx;
  logic [3:0]         ram_rdata;
  logic [3:0]         word_old;
  logic [3:0]         word_new;
  logic [3:0]         bit_mask;
  logic               ram_we;

  logic accept;
  logic drop;

  assign accept = start && !busy;
  assign drop   = !wrap_mode && (pixel_x > {2'b00, col_limit});

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_limit <= MAX_COLUMN_RST;
      max_row   <= MAX_ROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_COLUMN: col_limit <= cfg_data;
        REG_MAX_ROW:    max_row   <= cfg_data[2:0];
        default:        max_row   <= max_row;
      endcase
    end
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial    = {rem, div_num[7]};
  assign rem_step = (trial >= {1'b0, div_den}) ? 6'(trial - {1'b0, div_den}) : trial[5:0];

  // fitted coordinates at the end of each pass
  always_comb begin
    if (p_wrap && (px > {2'b00, col_limit})) begin
      fx = (col_limit == 6'd0) ? 6'd0 : rem_step;
    end else begin
      fx = px[5:0];
    end
    if (py > {5'b00000, max_row}) begin
      if (p_wrap) begin
        fy_step = (max_row == 3'd0) ? 3'd0 : rem_step[2:0];
      end else begin
        fy_step = max_row;
      end
    end else begin
      fy_step = py[2:0];
    end
  end

  // shadow word update
  assign cell_idx = wr_addr[CELL_AW-1:0];
  assign word_old = cell_valid[cell_idx] ? ram_rdata : 4'd0;
  assign bit_mask = 4'b1000 >> plot_sel;
  assign word_new = p_on ? (word_old | bit_mask) : (word_old & ~bit_mask);
  assign ram_we   = (state == ST_UPDATE);

  lmp_ram #(
    .WIDTH(4),
    .DEPTH(CELLS)
  ) u_shadow (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cell_idx),
    .wdata(word_new),
    .raddr(cell_idx),
    .rdata(ram_rdata)
  );

  // valid bits stand in for a cleared memory
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
    end else if (ram_we) begin
      cell_valid[cell_idx] <= 1'b1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and outputs
  always_comb begin
    state_next = state;
    busy       = (state != ST_IDLE);
    strobe     = (state == ST_SEND);
    serial_bit = frame[FRAME_W-1];
    frame_end  = (state == ST_SEND) && (bits_left == 4'd1);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_FRAME, CMD_WRITE: state_next = ST_SEND;
            CMD_PLOT:             state_next = drop ? ST_IDLE : ST_DIVX;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIVX:   if (div_cnt == 3'd0) state_next = ST_DIVY;
      ST_DIVY:   if (div_cnt == 3'd0) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = p_ram_only ? ST_IDLE : ST_SEND;
      ST_SEND:   if (bits_left == 4'd1) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= 4'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            px         <= pixel_x;
            py         <= pixel_y;
            p_on       <= pixel_on;
            p_wrap     <= wrap_mode;
            p_ram_only <= ram_only;
            div_num    <= pixel_x;
            div_den    <= col_limit;
            rem        <= 6'd0;
            div_cnt    <= 3'd7;
            if (command == CMD_FRAME) begin
              frame     <= {ID_CMD, command_byte, 1'b0, 2'b00};
              bits_left <= LEN_CMD;
            end else begin
              frame     <= {ID_WR, word_address, nibble};
              bits_left <= LEN_WR;
            end
          end
        end
        ST_DIVX: begin
          if (div_cnt == 3'd0) begin
            wr_addr[6:1] <= fx;
            div_num      <= py;
            div_den      <= {3'b000, max_row};
            rem          <= 6'd0;
            div_cnt      <= 3'd7;
          end else begin
            div_num <= {div_num[6:0], 1'b0};
            rem     <= rem_step;
            div_cnt <= div_cnt - 3'd1;
          end
        end
        ST_DIVY: begin
          if (div_cnt == 3'd0) begin
            wr_addr[0] <= fy_step[2];
            plot_sel   <= fy_step[1:0];
          end else begin
            div_num <= {div_num[6:0], 1'b0};
            rem     <= rem_step;
            div_cnt <= div_cnt - 3'd1;
          end
        end
        ST_UPDATE: begin
          frame     <= {ID_WR, wr_addr, word_new};
          bits_left <= LEN_WR;
        end
        ST_SEND: begin
          frame     <= {frame[FRAME_W-2:0], 1'b0};
          bits_left <= bits_left - 4'd1;
        end
        default: begin
          bits_left <= bits_left;
        end
      endcase
    end
  end

  // checks
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe while idle");

  a_end_on_strobe: assert property (@(posedge clk) disable iff (rst)
    frame_end |-> strobe) else $error("frame_end without strobe");

  a_gap_after_frame: assert property (@(posedge clk) disable iff (rst)
    frame_end |=> !strobe) else $error("bit sent right after frame end");

  a_unused_code: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_NONE) |=> !busy) else $error("unused code started work");

  a_cmd_frame_id: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_FRAME) |=> (strobe && serial_bit))
    else $error("command frame did not open with its ID");

endmodule
